// ----- rtl/xss_pkg.sv -----
// Shared types, constants and helpers for the xoshiro256** generator.
`default_nettype none

package xss_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned RANGE_W   = 32;
    localparam int unsigned SPAN_W    = RANGE_W + 1;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned WIDX_W    = $clog2(NUM_WORDS);
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned ADDR_W    = 4;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'hDEAD_BEEF_CAFE_F00D;

    localparam int unsigned ROT_STATE = 45;
    localparam int unsigned SHIFT_T   = 17;
    localparam int unsigned ROT_OUT   = 7;

    // Request codes.
    localparam logic [1:0] REQ_RESEED = 2'd0;
    localparam logic [1:0] REQ_RAW    = 2'd1;
    localparam logic [1:0] REQ_RANGE  = 2'd2;

    // Register index, taken from paddr above the byte offset.
    localparam logic REG_SEED = 1'b0;

    // Partial-product phases of the 64x64 low-half multiply.
    localparam logic [1:0] MUL_P0 = 2'd0;
    localparam logic [1:0] MUL_P1 = 2'd1;
    localparam logic [1:0] MUL_P2 = 2'd2;

    localparam logic [CNT_W-1:0]  CNT_DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [WIDX_W-1:0] WORD_LAST    = WIDX_W'(NUM_WORDS - 1);

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [RANGE_W-1:0] range_low;
        logic signed [RANGE_W-1:0] range_high;
    } xss_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]         raw_draw;
        logic signed [RANGE_W-1:0] ranged_draw;
    } xss_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM_ADD,
        ST_SM_MIX30,
        ST_SM_MULA,
        ST_SM_MIX27,
        ST_SM_MULB,
        ST_SM_FIN,
        ST_DRAW_ROT,
        ST_DRAW_STEP,
        ST_DIV,
        ST_FIN_RAW,
        ST_FIN_RANGE,
        ST_FIN_EMPTY
    } xss_state_t;

    typedef struct packed {
        logic              ld_req;
        logic              sm_init;
        logic              sm_add;
        logic              sm_mix30;
        logic              sm_mix27;
        logic              mul_en;
        logic              mul_b;
        logic [1:0]        mul_phase;
        logic              sm_store;
        logic [WIDX_W-1:0] word;
        logic              draw_rot;
        logic              draw_step;
        logic              div_step;
        logic              out_raw;
        logic              out_range;
        logic              out_empty;
    } xss_cmd_t;

    typedef struct packed {
        logic range_empty;
    } xss_sts_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                input int unsigned n);
        rotl64 = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/xoshiro256ss_generator_unit.sv -----
// Top level of the xoshiro256** generator with splitmix64 seeding and APB seed register.
`default_nettype none

// A raw request passes the rotate, step and finish states before the done strobe;
// a range request also runs the bit-serial remainder loop, and a range request whose
// high bound is not above its low bound goes straight to its finish state. A reseed
// keeps busy high through four splitmix steps, each with two multiplies as three 32x32
// partial products. One request is in flight at a time.
// Reset clears the seed register, the controller, the strobe and the generator words.
module xoshiro256ss_generator_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [xss_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [xss_pkg::DATA_W-1:0]  pwdata,
    output logic [xss_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  wire logic                        start,
    output logic                             busy,
    input  wire xss_pkg::xss_in_t            request,
    output logic                             done,
    output xss_pkg::xss_out_t                result
);
    import xss_pkg::*;

    logic [WORD_W-1:0] seed_reg, seed_next;
    logic              reg_idx;
    logic              cfg_wr;
    xss_cmd_t          cmd;
    xss_sts_t          sts;

    // The single 64-bit register sits at byte address 0; the upper address
    // bit selects the register slot, and writes to any other slot are dropped.
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        seed_next = seed_reg;
        if (cfg_wr && reg_idx == REG_SEED)
        begin
            seed_next = pwdata;
        end
    end

    assign prdata = (reg_idx == REG_SEED) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    // The controller sequences every request; the datapath holds the state
    // words and does the arithmetic under its commands.
    xss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    xss_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .seed    (seed_reg),
        .sts     (sts),
        .result  (result)
    );

endmodule

`default_nettype wire

// ----- rtl/xss_ctrl.sv -----
// Sequencing state machine for reseed, draw and range division.
`default_nettype none

module xss_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       req_type,
    input  wire xss_pkg::xss_sts_t sts,
    output xss_pkg::xss_cmd_t     cmd,
    output logic                  busy,
    output logic                  done
);
    import xss_pkg::*;

    xss_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIDX_W-1:0] word_reg, word_next;
    logic              range_reg, range_next;
    logic              done_reg, done_next;

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        range_next = range_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    case (req_type)
                        REQ_RESEED:
                        begin
                            state_next = ST_SM_ADD;
                            word_next  = '0;
                        end
                        REQ_RAW:
                        begin
                            state_next = ST_DRAW_ROT;
                            range_next = 1'b0;
                        end
                        REQ_RANGE:
                        begin
                            range_next = 1'b1;
                            state_next = sts.range_empty ? ST_FIN_EMPTY : ST_DRAW_ROT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SM_ADD:   state_next = ST_SM_MIX30;
            ST_SM_MIX30: state_next = ST_SM_MULA;
            ST_SM_MULA:
            begin
                if (cnt_reg[1:0] == MUL_P2)
                begin
                    cnt_next   = '0;
                    state_next = ST_SM_MIX27;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SM_MIX27: state_next = ST_SM_MULB;
            ST_SM_MULB:
            begin
                if (cnt_reg[1:0] == MUL_P2)
                begin
                    cnt_next   = '0;
                    state_next = ST_SM_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SM_FIN:
            begin
                word_next  = word_reg + 1'b1;
                state_next = (word_reg == WORD_LAST) ? ST_IDLE : ST_SM_ADD;
            end
            ST_DRAW_ROT:  state_next = ST_DRAW_STEP;
            ST_DRAW_STEP:
            begin
                cnt_next   = '0;
                state_next = range_reg ? ST_DIV : ST_FIN_RAW;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_DIV_LAST)
                begin
                    state_next = ST_FIN_RANGE;
                end
            end
            ST_FIN_RAW:   state_next = ST_IDLE;
            ST_FIN_RANGE: state_next = ST_IDLE;
            ST_FIN_EMPTY: state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.word      = word_reg;
        cmd.mul_phase = cnt_reg[1:0];
        busy          = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ld_req  = start;
                cmd.sm_init = start && (req_type == REQ_RESEED);
            end
            ST_SM_ADD:    cmd.sm_add   = 1'b1;
            ST_SM_MIX30:  cmd.sm_mix30 = 1'b1;
            ST_SM_MULA:   cmd.mul_en   = 1'b1;
            ST_SM_MIX27:  cmd.sm_mix27 = 1'b1;
            ST_SM_MULB:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_b  = 1'b1;
            end
            ST_SM_FIN:    cmd.sm_store  = 1'b1;
            ST_DRAW_ROT:  cmd.draw_rot  = 1'b1;
            ST_DRAW_STEP: cmd.draw_step = 1'b1;
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_FIN_RAW:   cmd.out_raw   = 1'b1;
            ST_FIN_RANGE: cmd.out_range = 1'b1;
            ST_FIN_EMPTY: cmd.out_empty = 1'b1;
            default:      cmd = '0;
        endcase
    end

    assign done_next = cmd.out_raw | cmd.out_range | cmd.out_empty;
    assign done      = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            word_reg  <= '0;
            range_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            word_reg  <= word_next;
            range_reg <= range_next;
            done_reg  <= done_next;
        end
    end

    // A result strobe is never held: it always drops again right after it rises.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // Reseed ends after the fourth state word is stored.
    a_reseed_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SM_FIN && word_reg == WORD_LAST) |=> state_reg == ST_IDLE)
        else $error("reseed did not finish after the last word");

    // The division ends on its last dividend bit.
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_DIV_LAST) |=> state_reg == ST_FIN_RANGE)
        else $error("division did not finish on its last bit");

    // An empty range goes straight to its finish state and answers without touching the generator.
    a_empty_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_RANGE && sts.range_empty)
            |=> ##1 done_reg)
        else $error("empty range request was not answered directly");

endmodule

`default_nettype wire

// ----- rtl/xss_dp.sv -----
// Datapath: generator state, splitmix expansion, draw and range remainder.
`default_nettype none

module xss_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire xss_pkg::xss_cmd_t         cmd,
    input  wire xss_pkg::xss_in_t          request,
    input  wire logic [xss_pkg::WORD_W-1:0] seed,
    output xss_pkg::xss_sts_t              sts,
    output xss_pkg::xss_out_t              result
);
    import xss_pkg::*;

    logic [WORD_W-1:0]  w_reg [NUM_WORDS];
    logic [WORD_W-1:0]  acc_reg;
    logic [WORD_W-1:0]  z_reg;
    logic [WORD_W-1:0]  prod_reg;
    logic [WORD_W-1:0]  raw_reg;
    logic [WORD_W-1:0]  dvd_reg;
    logic [RANGE_W-1:0] rem_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [RANGE_W-1:0] lo_reg;
    xss_out_t           out_reg;

    logic [WORD_W-1:0]  mul_k;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [WORD_W-1:0]  mul_p;
    logic [WORD_W-1:0]  mul_acc;
    logic [WORD_W-1:0]  acc_next;
    logic [WORD_W-1:0]  raw_next;
    logic [WORD_W-1:0]  t_word;
    logic [WORD_W-1:0]  w2_x;
    logic [WORD_W-1:0]  w3_x;
    logic [SPAN_W-1:0]  rem_t;
    logic [SPAN_W-1:0]  span_next;

    assign sts.range_empty = ($signed(request.range_high) <= $signed(request.range_low));

    // Span of the bounds, never overflowing at 33 bits when high > low.
    assign span_next = SPAN_W'({request.range_high[RANGE_W-1], request.range_high})
                     - SPAN_W'({request.range_low[RANGE_W-1], request.range_low})
                     + SPAN_W'(1);

    assign acc_next = acc_reg + GOLDEN_GAMMA;

    // Shared 32x32 multiplier walks the three partial products that reach
    // the low 64 bits of the product.
    assign mul_k = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;

    always_comb
    begin
        case (cmd.mul_phase)
            MUL_P0:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_k[31:0];
            end
            MUL_P1:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_k[63:32];
            end
            default:
            begin
                mul_a = z_reg[63:32];
                mul_b = mul_k[31:0];
            end
        endcase
    end

    assign mul_p   = WORD_W'(mul_a) * WORD_W'(mul_b);
    assign mul_acc = prod_reg + {mul_p[31:0], 32'b0};

    assign raw_next = z_reg + (z_reg << 3);
    assign t_word   = w_reg[1] << SHIFT_T;
    assign w2_x     = w_reg[2] ^ w_reg[0];
    assign w3_x     = w_reg[3] ^ w_reg[1];

    assign rem_t = {rem_reg, dvd_reg[WORD_W-1]};

    // The generator words start at zero and give zero draws until a reseed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else if (cmd.sm_store)
        begin
            w_reg[cmd.word] <= z_reg ^ (z_reg >> 31);
        end
        else if (cmd.draw_step)
        begin
            w_reg[0] <= w_reg[0] ^ w3_x;
            w_reg[1] <= w_reg[1] ^ w2_x;
            w_reg[2] <= w2_x ^ t_word;
            w_reg[3] <= rotl64(w3_x, ROT_STATE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_req)
        begin
            lo_reg   <= request.range_low;
            span_reg <= span_next;
        end

        if (cmd.sm_init)
        begin
            acc_reg <= (seed == '0) ? DEFAULT_SEED : seed;
        end
        if (cmd.sm_add)
        begin
            acc_reg <= acc_next;
            z_reg   <= acc_next;
        end
        if (cmd.sm_mix30)
        begin
            z_reg <= z_reg ^ (z_reg >> 30);
        end
        if (cmd.sm_mix27)
        begin
            z_reg <= z_reg ^ (z_reg >> 27);
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_phase)
                MUL_P0:  prod_reg <= mul_p;
                MUL_P1:  prod_reg <= mul_acc;
                MUL_P2:  z_reg    <= mul_acc;
                default: prod_reg <= prod_reg;
            endcase
        end

        if (cmd.draw_rot)
        begin
            z_reg <= rotl64(w_reg[1] + (w_reg[1] << 2), ROT_OUT);
        end
        if (cmd.draw_step)
        begin
            raw_reg  <= raw_next;
            dvd_reg  <= raw_next;
            rem_reg  <= '0;
        end

        // Restoring remainder, one dividend bit per cycle.
        if (cmd.div_step)
        begin
            rem_reg <= (rem_t >= span_reg) ? RANGE_W'(rem_t - span_reg)
                                           : RANGE_W'(rem_t);
            dvd_reg <= dvd_reg << 1;
        end

        if (cmd.out_raw)
        begin
            out_reg.raw_draw    <= raw_reg;
            out_reg.ranged_draw <= '0;
        end
        if (cmd.out_range)
        begin
            out_reg.raw_draw    <= raw_reg;
            out_reg.ranged_draw <= lo_reg + rem_reg;
        end
        if (cmd.out_empty)
        begin
            out_reg.raw_draw    <= '0;
            out_reg.ranged_draw <= lo_reg;
        end
    end

    assign result = out_reg;

endmodule

`default_nettype wire

// ----- dv/xoshiro256ss_generator_unit_test.sv -----
// Self-checking testbench for the xoshiro256** generator unit with APB seed register.
`timescale 1ns / 1ps

module xoshiro256ss_generator_unit_test;

    import xss_pkg::*;

    // The unused request code is not named in the package. It must be ignored.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Register index above the seed. The block must ignore writes to it.
    localparam logic REG_SPARE = 1'b1;

    localparam logic [RANGE_W-1:0] RANGE_MIN = 32'h8000_0000;
    localparam logic [RANGE_W-1:0] RANGE_MAX = 32'h7FFF_FFFF;
    localparam longint             SMIN      = -64'sd2147483648;
    localparam longint             SMAX      = 64'sd2147483647;

    // The range draw has the longest latency. A reseed keeps busy high
    // and gives no result. Before a register write we therefore let
    // a little more than the worst latency pass after the last result.
    localparam int SETTLE_CYCLES = 80;

    // The slowest correct run is about 1100 requests, plus sender gaps,
    // reseeds and the register pauses. That stays well below CYCLE_LIMIT.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PER_PHASE = 259;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    logic                 start = 1'b0;
    logic                 busy;
    xss_in_t              request = '0;
    logic                 done;
    xss_out_t             result;

    xoshiro256ss_generator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // The predictor keeps its own copy of the seed register and of the
    // four generator words.
    logic [WORD_W-1:0] seed_reg = '0;
    logic [WORD_W-1:0] gen_words [NUM_WORDS];

    // Requests waiting for the driver, and the draws that the block still owes us.
    xss_in_t  queued_requests [$];
    xss_out_t expected_draws [$];

    // The sender leaves the start line low on this percentage of its chances.
    int unsigned idle_pct = 0;

    // The monitor sets this at the rising edge that took a request. The driver
    // reads it at the following falling edge.
    logic req_taken = 1'b0;

    int error_count = 0;
    int cycle_count = 0;
    int n_raw = 0;
    int n_ranged = 0;
    int n_empty = 0;
    int n_reseeds = 0;
    int n_ignored = 0;
    int n_reg_writes = 0;
    int n_results = 0;

    initial begin
        forever #10 clk = ~clk;
    end

    // This is the output scrambler of splitmix64, applied to an accumulator
    // that has already been advanced.
    function automatic logic [WORD_W-1:0] splitmix_mix(input logic [WORD_W-1:0] acc);
        logic [WORD_W-1:0] z;
        z = (acc ^ (acc >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // This is one xoshiro256** step. It returns the scrambled output of the
    // old second word and then advances the four generator words.
    function automatic logic [WORD_W-1:0] draw_and_advance();
        logic [WORD_W-1:0] times5;
        logic [WORD_W-1:0] draw;
        logic [WORD_W-1:0] t;
        times5 = gen_words[1] * 64'd5;
        draw = {times5[56:0], times5[63:57]} * 64'd9;
        t = gen_words[1] << 17;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ t;
        gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
        return draw;
    endfunction

    // This works out what one accepted request does to the generator state,
    // and queues the draw that the block must return for it.
    task automatic predict_request(input xss_in_t req);
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] sum;
        longint lo_s;
        longint hi_s;
        xss_out_t want;
        case (req.req_type)
            REQ_RESEED:
            begin
                // A zero seed falls back to the built-in default.
                acc = (seed_reg != '0) ? seed_reg : DEFAULT_SEED;
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    acc = acc + GOLDEN_GAMMA;
                    gen_words[i] = splitmix_mix(acc);
                end
                n_reseeds++;
            end
            REQ_RAW:
            begin
                want.raw_draw = draw_and_advance();
                want.ranged_draw = '0;
                expected_draws.push_back(want);
                n_raw++;
            end
            REQ_RANGE:
            begin
                lo_s = {{32{req.range_low[RANGE_W-1]}}, req.range_low};
                hi_s = {{32{req.range_high[RANGE_W-1]}}, req.range_high};
                if (hi_s <= lo_s)
                begin
                    // An empty or inverted range returns the low bound without a draw.
                    want.raw_draw = '0;
                    want.ranged_draw = req.range_low;
                    n_empty++;
                end
                else
                begin
                    // The span is taken at 64 bits, so the full 32-bit range
                    // gives 2**32 and does not overflow.
                    span = 64'(hi_s - lo_s) + 64'd1;
                    want.raw_draw = draw_and_advance();
                    sum = 64'(lo_s) + (want.raw_draw % span);
                    want.ranged_draw = sum[RANGE_W-1:0];
                    n_ranged++;
                end
                expected_draws.push_back(want);
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endtask

    // The driver changes its outputs on the falling edge. A request stays on
    // the port until the block takes it. Only after that does the sender either
    // put up the next request or leave start low. Each step gives start at
    // most one assignment.
    always @(negedge clk)
    begin : request_driver
        logic    next_start;
        xss_in_t next_req;
        if (rst_n && (!start || req_taken))
        begin
            next_start = 1'b0;
            next_req = request;
            if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_start = 1'b1;
                next_req = queued_requests.pop_front();
            end
            start <= next_start;
            request <= next_req;
        end
    end

    // The monitor samples at the rising edge. The block updates its outputs
    // with nonblocking assignments, so we see the values from before the edge.
    // The result check comes before the prediction for any request taken at
    // the same edge. That request cannot have its result out yet.
    always @(posedge clk)
    begin : draw_monitor
        xss_out_t want;
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                n_results++;
                if (expected_draws.size() == 0)
                begin
                    $display("%0t: unexpected result raw_draw %h ranged_draw %0d",
                             $time, result.raw_draw, result.ranged_draw);
                    error_count++;
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (result.raw_draw !== want.raw_draw)
                    begin
                        $display("%0t: raw_draw mismatch: expected %h, actual %h",
                                 $time, want.raw_draw, result.raw_draw);
                        error_count++;
                    end
                    if (result.ranged_draw !== want.ranged_draw)
                    begin
                        $display("%0t: ranged_draw mismatch: expected %0d, actual %0d",
                                 $time, want.ranged_draw, result.ranged_draw);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                req_taken = 1'b1;
                predict_request(request);
            end
        end
    end

    // This is the watchdog. If something hangs, the run still ends.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d draws still owed",
                     cycle_count, expected_draws.size());
            $display("** xoshiro256ss_generator_unit: FAILED **");
            $finish;
        end
    end

    task automatic queue_request(input logic [1:0] kind, input logic [RANGE_W-1:0] lo,
                                 input logic [RANGE_W-1:0] hi);
        xss_in_t req;
        req.req_type = kind;
        req.range_low = lo;
        req.range_high = hi;
        queued_requests.push_back(req);
    endtask

    function automatic logic [RANGE_W-1:0] clamp_to_range(input longint v);
        if (v > SMAX)
            return RANGE_MAX;
        if (v < SMIN)
            return RANGE_MIN;
        return v[RANGE_W-1:0];
    endfunction

    // Most random traffic is draws. The bounds come from a mix of shapes:
    // fully random, short spans, empty or inverted ranges, ranges near the
    // extremes, and power-of-two spans. A few reseeds and unused codes are mixed in.
    function automatic xss_in_t random_request();
        xss_in_t req;
        int unsigned pick;
        longint lo_s;
        longint hi_s;
        pick = $urandom_range(99);
        req.range_low = $urandom;
        req.range_high = $urandom;
        if (pick < 4)
            req.req_type = REQ_RESEED;
        else if (pick < 7)
            req.req_type = REQ_UNUSED;
        else if (pick < 35)
            req.req_type = REQ_RAW;
        else
        begin
            req.req_type = REQ_RANGE;
            lo_s = {{32{req.range_low[RANGE_W-1]}}, req.range_low};
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                end
                4, 5, 6:
                begin
                    req.range_high = clamp_to_range(lo_s + longint'($urandom_range(1, 255)));
                end
                7:
                begin
                    if ($urandom_range(1) == 0)
                        req.range_high = req.range_low;
                    else
                        req.range_high = clamp_to_range(lo_s -
                                                        longint'($urandom_range(1, 1000)));
                end
                8:
                begin
                    req.range_low = RANGE_MIN + $urandom_range(15);
                    req.range_high = RANGE_MAX - $urandom_range(15);
                end
                default:
                begin
                    hi_s = lo_s + (longint'(1) << $urandom_range(31)) - 1;
                    req.range_high = clamp_to_range(hi_s);
                end
            endcase
        end
        return req;
    endfunction

    // An APB write has a setup phase and then an access phase. It completes at
    // the edge where the access phase meets pready.
    task automatic apb_write(input logic reg_idx, input logic [DATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (reg_idx == REG_SEED)
            seed_reg = value;
        n_reg_writes++;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // This reads the seed register back and checks it against our copy.
    task automatic apb_check_seed();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {REG_SEED, 3'b000};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== seed_reg)
        begin
            $display("%0t: seed readback mismatch: expected %h, actual %h",
                     $time, seed_reg, prdata);
            error_count++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // First every queued request is taken and every owed draw has arrived.
    // Then we wait out a reseed that may still be running,
    // so that the block is truly idle before its register is touched.
    task automatic wait_until_idle();
        while (queued_requests.size() != 0 || start || expected_draws.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [DATA_W-1:0] phase_seed;
        // The generator words come out of reset as zero.
        for (int i = 0; i < NUM_WORDS; i++)
            gen_words[i] = '0;
        // Reset is held low at first and released on a falling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Before the first reseed the generator words are all
        // zero, so draws come out as zero and the state stays put. The seed
        // register is still zero from reset, which selects the default seed.
        idle_pct = 0;
        queue_request(REQ_RAW, '0, '0);
        queue_request(REQ_RANGE, -32'sd7, 32'd9);
        queue_request(REQ_RESEED, '0, '0);
        queue_request(REQ_RAW, '0, '0);
        queue_request(REQ_RAW, '1, '1);
        queue_request(REQ_RANGE, RANGE_MIN, RANGE_MAX);
        queue_request(REQ_RANGE, 32'd0, 32'd1);
        queue_request(REQ_RANGE, 32'd5, 32'd5);
        queue_request(REQ_RANGE, 32'd10, -32'sd10);
        queue_request(REQ_RANGE, RANGE_MAX, RANGE_MIN);
        queue_request(REQ_RANGE, RANGE_MIN, RANGE_MIN + 32'd1);
        queue_request(REQ_RANGE, RANGE_MAX - 32'd1, RANGE_MAX);
        queue_request(REQ_RANGE, -32'sd1, 32'd0);
        queue_request(REQ_UNUSED, RANGE_MIN, RANGE_MAX);
        queue_request(REQ_RANGE, -32'sd100, 32'd100);
        queue_request(REQ_RANGE, 32'd0, RANGE_MAX);
        queue_request(REQ_RANGE, RANGE_MIN, 32'd0);
        wait_until_idle();

        // Next we try the all-ones seed and read it back.
        apb_write(REG_SEED, '1);
        apb_check_seed();
        queue_request(REQ_RESEED, '0, '0);
        queue_request(REQ_RAW, '0, '0);
        queue_request(REQ_RANGE, RANGE_MIN, RANGE_MAX);
        wait_until_idle();

        // A write to the spare register must leave the seed alone.
        apb_write(REG_SPARE, {$urandom, $urandom});
        apb_check_seed();
        apb_write(REG_SEED, 64'd1);
        queue_request(REQ_RESEED, '0, '0);
        queue_request(REQ_RAW, '0, '0);
        wait_until_idle();

        // Random phases. Each one sets a new seed and opens with a reseed, so
        // the draws that follow come from that seed. Sender idling varies from
        // phase to phase.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    phase_seed = {$urandom, $urandom};
                    idle_pct = 0;
                end
                1:
                begin
                    phase_seed = '0;
                    idle_pct = 49;
                end
                2:
                begin
                    phase_seed = 64'h8000_0000_0000_0000;
                    idle_pct = 11;
                end
                default:
                begin
                    phase_seed = {$urandom, $urandom};
                    idle_pct = 0;
                end
            endcase
            apb_write(REG_SEED, phase_seed);
            queue_request(REQ_RESEED, '0, '0);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                queued_requests.push_back(random_request());
            wait_until_idle();
        end

        $display("Covered %0d raw draws, %0d range draws, %0d empty ranges, %0d reseeds,",
                 n_raw, n_ranged, n_empty, n_reseeds);
        $display("%0d ignored requests, %0d register writes and %0d results checked.",
                 n_ignored, n_reg_writes, n_results);
        if (error_count == 0)
            $display("** xoshiro256ss_generator_unit: PASSED **");
        else
            $display("** xoshiro256ss_generator_unit: FAILED **");
        $finish;
    end

endmodule
